>>> rtl/bcsd_pkg.sv
// Shared types, character constants and classification functions for the
// quoted-string byte-code decoder. No dependencies; every file but bcsd_if uses it.
`default_nettype none

package bcsd_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_BAR     = 8'h7C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] HEX_TEN      = 8'd10;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Hex digits held by the back end
   localparam logic [1:0] NIBBLES_FULL = 2'd2;

   typedef enum logic [2:0] {
      CLS_WS,
      CLS_BANG,
      CLS_QUOTE,
      CLS_BAR,
      CLS_HEX,
      CLS_OTHER
   } char_class_type;

   // One classified character as it travels through the queue
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     nibble;
      logic [7:0]     char_code;
      logic           is_last;
      logic           ends_with_quote;
   } item_type;

   function automatic logic is_ws(input logic [7:0] ch);
      return (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
   endfunction

   function automatic logic is_hex(input logic [7:0] ch);
      return ((ch >= CHAR_ZERO) && (ch <= CHAR_NINE)) ||
             ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_F)) ||
             ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_F));
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] sum;
      if ((ch >= CHAR_ZERO) && (ch <= CHAR_NINE)) begin
         sum = ch - CHAR_ZERO;
      end else if ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_F)) begin
         sum = ch - CHAR_UPPER_A + HEX_TEN;
      end else begin
         sum = ch - CHAR_LOWER_A + HEX_TEN;
      end
      return sum[3:0];
   endfunction

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type cls;
      if (ch == CHAR_BANG) begin
         cls = CLS_BANG;
      end else if (ch == CHAR_QUOTE) begin
         cls = CLS_QUOTE;
      end else if (ch == CHAR_BAR) begin
         cls = CLS_BAR;
      end else if (is_hex(ch)) begin
         cls = CLS_HEX;
      end else if (is_ws(ch)) begin
         cls = CLS_WS;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bcsd_if.sv
// Valid/ready channel interfaces for characters in and decoded results out.
// Depends on nothing.
`default_nettype none

interface bcsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;
   logic       ends_with_quote;

   modport source (output valid, output char_code, output is_last,
                   output ends_with_quote, input ready);
   modport sink   (input valid, input char_code, input is_last,
                   input ends_with_quote, output ready);
endinterface

interface bcsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] byte_value;
   logic       string_done;
   logic       parse_ok;
   logic       negated;

   modport source (output valid, output byte_valid, output byte_value,
                   output string_done, output parse_ok, output negated,
                   input ready);
   modport sink   (input valid, input byte_valid, input byte_value,
                   input string_done, input parse_ok, input negated,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/byte_code_string_decoder.sv
// Quoted-string byte-code decoder, top level.
// Depends on bcsd_pkg, bcsd_if, bcsd_front, bcsd_queue and bcsd_back.
//
// Usage:
//   req_chan carries one character of a pattern string per beat, with
//   is_last on the final character and ends_with_quote telling whether that
//   final character is a double quote. rsp_chan returns exactly one beat per
//   character: an optional decoded byte, string_done, parse_ok and negated.
//   A character accepted on req_chan is classified and written into the queue;
//   the parser takes it from the queue head once the output register is free
//   or being drained, and registers its result, which rsp_chan then presents.
//   Throughput: one character per cycle while rsp_chan.ready stays high, set
//   by the parser step in the back end; the two-entry queue keeps the front
//   accepting while a result waits.
//   Reset (synchronous, active high) empties the queue and output register
//   and returns the parser to its start state; state also returns there after
//   every last character.
//   When the receiver stalls, the result register holds, the queue fills, and
//   req_chan.ready drops once both queue entries are occupied.
`default_nettype none

module byte_code_string_decoder (
   input  logic       clock,
   input  logic       reset,
   bcsd_req_if.sink   req_chan,
   bcsd_rsp_if.source rsp_chan
);

   logic               queue_full;
   logic               queue_not_empty;
   logic               push;
   logic               pop;
   bcsd_pkg::item_type push_item;
   bcsd_pkg::item_type head_item;

   bcsd_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   bcsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_item  (head_item)
   );

   bcsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (queue_not_empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

>>> rtl/bcsd_front.sv
// Front end: accepts characters and classifies them for the back end.
// Depends on bcsd_pkg and bcsd_req_if.
`default_nettype none

module bcsd_front (
   bcsd_req_if.sink          req_chan,
   input  logic              queue_full,
   output logic              push,
   output bcsd_pkg::item_type push_item
);

   // Accept whenever the queue has room
   assign req_chan.ready = ~queue_full;
   assign push           = req_chan.valid & ~queue_full;

   // Classify the character and precompute its hex digit value
   always_comb begin
      push_item.cls             = bcsd_pkg::classify(req_chan.char_code);
      push_item.nibble          = bcsd_pkg::hex_nibble(req_chan.char_code);
      push_item.char_code       = req_chan.char_code;
      push_item.is_last         = req_chan.is_last;
      push_item.ends_with_quote = req_chan.ends_with_quote;
   end

endmodule

`default_nettype wire

>>> rtl/bcsd_queue.sv
// Short queue of classified characters between front and back end.
// Depends on bcsd_pkg.
`default_nettype none

module bcsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bcsd_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output bcsd_pkg::item_type head_item
);

   bcsd_pkg::item_type                   mem_ff [bcsd_pkg::QUEUE_DEPTH];
   logic [bcsd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bcsd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bcsd_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == bcsd_pkg::QUEUE_CNT_W'(bcsd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue read while empty");

endmodule

`default_nettype wire

>>> rtl/bcsd_back.sv
// Back end: runs the string parser on classified characters and holds the
// result in an output register. Depends on bcsd_pkg and bcsd_rsp_if.
`default_nettype none

module bcsd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  bcsd_pkg::item_type head_item,
   output logic               pop,
   bcsd_rsp_if.source         rsp_chan
);

   typedef enum logic [1:0] {
      MODE_START,
      MODE_BANG,
      MODE_TEXT,
      MODE_HEX
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] acc_ff, acc_in;
   logic [1:0] nib_ff, nib_in;
   logic       neg_ff, neg_in;
   logic       err_ff, err_in;

   logic       out_valid_ff;
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_value_ff, byte_value_in;
   logic       done_ff;
   logic       ok_ff, ok_in;
   logic       negated_ff, negated_in;

   // Take the head beat when the output register is free or being drained
   assign pop = not_empty & (~out_valid_ff | rsp_chan.ready);

   // Parser step for one character
   always_comb begin
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      nib_in        = nib_ff;
      neg_in        = neg_ff;
      err_in        = err_ff;
      byte_valid_in = 1'b0;
      byte_value_in = '0;
      if (!err_ff) begin
         case (mode_ff)
            MODE_START, MODE_BANG: begin
               if (mode_ff == MODE_START && head_item.cls == bcsd_pkg::CLS_BANG) begin
                  neg_in  = 1'b1;
                  mode_in = MODE_BANG;
               end else if (head_item.cls == bcsd_pkg::CLS_QUOTE &&
                            head_item.ends_with_quote) begin
                  mode_in = MODE_TEXT;
               end else if (head_item.cls != bcsd_pkg::CLS_WS) begin
                  err_in = 1'b1;
               end
            end
            MODE_TEXT: begin
               // closing quote is dropped
               if (!head_item.is_last) begin
                  if (head_item.cls == bcsd_pkg::CLS_BAR) begin
                     acc_in  = '0;
                     nib_in  = '0;
                     mode_in = MODE_HEX;
                  end else begin
                     byte_valid_in = 1'b1;
                     byte_value_in = head_item.char_code;
                  end
               end
            end
            MODE_HEX: begin
               if (!head_item.is_last) begin
                  case (head_item.cls)
                     bcsd_pkg::CLS_BAR: begin
                        if (nib_ff != '0) begin
                           byte_valid_in = 1'b1;
                           byte_value_in = acc_ff;
                        end
                        mode_in = MODE_TEXT;
                     end
                     bcsd_pkg::CLS_HEX: begin
                        // flush a full pair before starting the next one
                        if (nib_ff >= bcsd_pkg::NIBBLES_FULL) begin
                           byte_valid_in = 1'b1;
                           byte_value_in = acc_ff;
                           acc_in        = {4'd0, head_item.nibble};
                           nib_in        = 2'd1;
                        end else begin
                           acc_in = {acc_ff[3:0], head_item.nibble};
                           nib_in = nib_ff + 1'b1;
                        end
                     end
                     bcsd_pkg::CLS_WS: begin
                        if (nib_ff != '0) begin
                           byte_valid_in = 1'b1;
                           byte_value_in = acc_ff;
                           acc_in        = '0;
                           nib_in        = '0;
                        end
                     end
                     default: begin
                        err_in = 1'b1;
                     end
                  endcase
               end
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end
      ok_in      = ~err_in;
      negated_in = neg_in;
   end

   // Hold parser state and the result register; drop state back to reset
   // after the last character
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_START;
         acc_ff        <= '0;
         nib_ff        <= '0;
         neg_ff        <= 1'b0;
         err_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         byte_valid_ff <= 1'b0;
         byte_value_ff <= '0;
         done_ff       <= 1'b0;
         ok_ff         <= 1'b0;
         negated_ff    <= 1'b0;
      end else begin
         if (pop) begin
            if (head_item.is_last) begin
               mode_ff <= MODE_START;
               acc_ff  <= '0;
               nib_ff  <= '0;
               neg_ff  <= 1'b0;
               err_ff  <= 1'b0;
            end else begin
               mode_ff <= mode_in;
               acc_ff  <= acc_in;
               nib_ff  <= nib_in;
               neg_ff  <= neg_in;
               err_ff  <= err_in;
            end
            out_valid_ff  <= 1'b1;
            byte_valid_ff <= byte_valid_in;
            byte_value_ff <= byte_value_in;
            done_ff       <= head_item.is_last;
            ok_ff         <= ok_in;
            negated_ff    <= negated_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.byte_valid  = byte_valid_ff;
   assign rsp_chan.byte_value  = byte_value_ff;
   assign rsp_chan.string_done = done_ff;
   assign rsp_chan.parse_ok    = ok_ff;
   assign rsp_chan.negated     = negated_ff;

   a_nib_range: assert property (@(posedge clock) disable iff (reset)
      nib_ff <= bcsd_pkg::NIBBLES_FULL)
      else $error("hex digit count out of range");

   a_byte_implies_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && byte_valid_ff |-> ok_ff)
      else $error("byte emitted on an errored string");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      pop && head_item.is_last |=> mode_ff == MODE_START && !err_ff && !neg_ff)
      else $error("parser state not cleared at end of string");

endmodule

`default_nettype wire
